// ===== src/pfb_pkg.sv =====
// Shared constants, opcode codes and controller/datapath bundles for the
// page frame buffer rasterizer. No dependencies; compile first.
package pfb_pkg;

    // Default geometry of the frame store
    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    // Fixed field widths of a command and a response
    localparam int OP_W   = 3;
    localparam int X_W    = 7;
    localparam int Y_W    = 6;
    localparam int R_W    = 7;
    localparam int DATA_W = 8;

    // Signed pixel coordinate width; circle points reach -127 .. 254
    localparam int CW = 10;

    // Circle state widths
    localparam int AB_W = 9;
    localparam int SQ_W = 16;

    // Opcodes
    localparam logic [OP_W-1:0] OP_POINT  = 3'd0;
    localparam logic [OP_W-1:0] OP_LINE   = 3'd1;
    localparam logic [OP_W-1:0] OP_CIRCLE = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture an accepted command
        logic setup;      // prepare line or circle stepping
        logic clear_en;   // write one zero byte of the clearing sweep
        logic pix_rd;     // read the byte under the current pixel
        logic pix_wr;     // write back the modified byte
        logic line_step;  // advance the line accumulator
        logic oct_step;   // move to the next of the eight circle points
        logic circ_step;  // advance the circle stepping
        logic emit;       // load the response register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            line_last;
        logic            circ_cont;
        logic            oct_last;
        logic            clr_last;
        logic            out_free;
    } dp_sts_t;

endpackage

// ===== src/pfb_cmd_if.sv =====
// Command channel: valid/ready handshake carrying one drawing command.
// Depends on pfb_pkg.
interface pfb_cmd_if;
    import pfb_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [X_W-1:0]   x_a;
    logic [Y_W-1:0]   y_a;
    logic [X_W-1:0]   x_b;
    logic [Y_W-1:0]   y_b;
    logic [R_W-1:0]   radius;
    logic             fill;

    modport source (output valid, opcode, x_a, y_a, x_b, y_b, radius, fill, input ready);
    modport sink (input valid, opcode, x_a, y_a, x_b, y_b, radius, fill, output ready);
endinterface

// ===== src/pfb_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one result beat.
// Depends on pfb_pkg.
interface pfb_rsp_if;
    import pfb_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              is_read;

    modport source (output valid, read_data, is_read, input ready);
    modport sink (input valid, read_data, is_read, output ready);
endinterface

// ===== src/page_framebuffer_line_circle_raster.sv =====
// Page frame buffer rasterizer: a COLUMNS x (8*PAGES) monochrome frame store
// kept as one byte per column per 8-row page (bit k of column x, page p is
// row 8*p+k). Each command beat on cmd gives exactly one response beat on
// rsp: opcode 0 sets or clears one pixel, 1 draws a line from (x_a, y_a) to
// (x_b, y_b), 2 sets a circle outline of the given radius around (x_a, y_a),
// 3 clears the store, 4 returns the byte at column x_a, page y_a/8 with
// is_read high; other opcodes change nothing. Pixels outside the store are
// dropped. Commands are taken one at a time. Each pixel is a read-modify-
// write on the frame memory (S_PIX_RD, then S_PIX_WR); a line plots
// max(|dx|,|dy|)+1 pixels, a circle eight pixels per stepping iteration,
// and a clear sweeps COLUMNS*PAGES bytes, one byte per cycle. After reset
// the same sweep zeroes the store with cmd.ready low. A finished response
// waits in an output register, so the next command is taken while rsp is
// stalled.
// Depends on pfb_pkg, pfb_cmd_if, pfb_rsp_if, pfb_ctrl and pfb_dp.
module page_framebuffer_line_circle_raster #(
    parameter int COLUMNS = pfb_pkg::COLUMNS_DEF,
    parameter int PAGES   = pfb_pkg::PAGES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    pfb_cmd_if.sink       cmd,
    pfb_rsp_if.source     rsp
);
    import pfb_pkg::*;

    dp_cmd_t ctl;
    dp_sts_t sts;

    // Sequencer: clearing sweep, command capture, per-pixel read and write
    pfb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (cmd.valid),
        .ready (cmd.ready),
        .sts   (sts),
        .ctl   (ctl)
    );

    // Frame memory, line and circle stepping, response register
    pfb_dp #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .opcode    (cmd.opcode),
        .x_a       (cmd.x_a),
        .y_a       (cmd.y_a),
        .x_b       (cmd.x_b),
        .y_b       (cmd.y_b),
        .radius    (cmd.radius),
        .fill      (cmd.fill),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .read_data (rsp.read_data),
        .is_read   (rsp.is_read)
    );

`ifndef NO_ASSERTIONS
    // Only a read beat carries data
    a_data_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.is_read |-> rsp.read_data == '0)
        else $error("nonzero read_data on a non-read response");

    // One command at a time: ready drops right after a beat is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("command taken while another is in progress");

    // Every memory write-back follows the read of the same pixel
    a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pix_wr |-> $past(ctl.pix_rd))
        else $error("pixel write without a preceding read");

    // A response is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> !rsp.valid || rsp.ready)
        else $error("response register overwritten");
`endif
endmodule

// ===== src/pfb_ctrl.sv =====
// Sequencing state machine of the page frame buffer rasterizer.
// Depends on pfb_pkg; drives pfb_dp through dp_cmd_t.
module pfb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              ready,
    input  pfb_pkg::dp_sts_t  sts,
    output pfb_pkg::dp_cmd_t  ctl
);
    import pfb_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_SETUP  = 8'b0000_0100,
        S_CTEST  = 8'b0000_1000,
        S_PIX_RD = 8'b0001_0000,
        S_PIX_WR = 8'b0010_0000,
        S_CSTEP  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   clr_cmd_reg, clr_cmd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cmd_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cmd_reg <= clr_cmd_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cmd_next = clr_cmd_reg;
        ctl          = '0;
        ready        = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clear_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next   = clr_cmd_reg ? S_DONE : S_IDLE;
                    clr_cmd_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                ready = 1'b1;
                if (valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                ctl.setup = 1'b1;
                unique case (sts.op)
                    OP_POINT, OP_LINE, OP_READ: state_next = S_PIX_RD;
                    OP_CIRCLE:                  state_next = S_CTEST;
                    OP_CLEAR:
                    begin
                        state_next   = S_CLEAR;
                        clr_cmd_next = 1'b1;
                    end
                    default:                    state_next = S_DONE;
                endcase
            end
            S_CTEST:
            begin
                state_next = sts.circ_cont ? S_PIX_RD : S_DONE;
            end
            S_PIX_RD:
            begin
                ctl.pix_rd = 1'b1;
                state_next = S_PIX_WR;
            end
            S_PIX_WR:
            begin
                ctl.pix_wr = 1'b1;
                priority if (sts.op == OP_LINE)
                begin
                    ctl.line_step = 1'b1;
                    state_next    = sts.line_last ? S_DONE : S_PIX_RD;
                end
                else if (sts.op == OP_CIRCLE)
                begin
                    ctl.oct_step = 1'b1;
                    state_next   = sts.oct_last ? S_CSTEP : S_PIX_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CSTEP:
            begin
                ctl.circ_step = 1'b1;
                state_next    = S_CTEST;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end
endmodule

// ===== src/pfb_dp.sv =====
// Datapath of the page frame buffer rasterizer: frame memory, line and
// circle stepping, clearing sweep and response register. Depends on pfb_pkg.
module pfb_dp #(
    parameter int COLUMNS = pfb_pkg::COLUMNS_DEF,
    parameter int PAGES   = pfb_pkg::PAGES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pfb_pkg::dp_cmd_t            ctl,
    output pfb_pkg::dp_sts_t            sts,
    input  logic [pfb_pkg::OP_W-1:0]    opcode,
    input  logic [pfb_pkg::X_W-1:0]     x_a,
    input  logic [pfb_pkg::Y_W-1:0]     y_a,
    input  logic [pfb_pkg::X_W-1:0]     x_b,
    input  logic [pfb_pkg::Y_W-1:0]     y_b,
    input  logic [pfb_pkg::R_W-1:0]     radius,
    input  logic                        fill,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pfb_pkg::DATA_W-1:0]  read_data,
    output logic                        is_read
);
    import pfb_pkg::*;

    localparam int DEPTH  = COLUMNS * PAGES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROWS   = 8 * PAGES;

    // Captured command
    logic [OP_W-1:0] op_reg;
    logic [X_W-1:0]  xa_reg, xb_reg;
    logic [Y_W-1:0]  ya_reg, yb_reg;
    logic [R_W-1:0]  rad_reg;
    logic            fill_reg;

    // Line stepping
    logic signed [CW-1:0] cx_reg, cx_next;
    logic signed [CW-1:0] cy_reg, cy_next;
    logic [X_W-1:0]       dx_reg, dist_reg, n_reg;
    logic [Y_W-1:0]       dy_reg;
    logic                 sx_neg_reg, sy_neg_reg;
    logic [X_W:0]         ex_reg, ex_next, ey_reg, ey_next;
    logic [X_W:0]         ex_sum, ey_sum;

    // Circle stepping
    logic signed [AB_W-1:0] ca_reg, cb_reg;
    logic [SQ_W-1:0]        asq_reg, bsq_reg, rsq_reg;
    logic [SQ_W-1:0]        asq_inc, bsq_dec;
    logic [2:0]             k_reg;

    // Pixel access
    logic [DATA_W-1:0]      mem [DEPTH];
    logic [DATA_W-1:0]      rd_data_reg, res_data_reg, wr_data;
    logic [ADDR_W-1:0]      waddr_reg, pix_addr, clr_cnt_reg;
    logic [DATA_W-1:0]      mask_reg, pix_mask;
    logic                   vis_reg, pix_vis, wr_en;
    logic signed [CW-1:0]   pix_x, pix_y, oct_x, oct_y;

    // Response register
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_read_reg;

    // Setup values for the line
    logic signed [X_W:0] dxs;
    logic signed [Y_W:0] dys;
    logic [X_W-1:0]      dx_abs;
    logic [Y_W-1:0]      dy_abs;

    always_comb
    begin
        dxs    = $signed({1'b0, xb_reg}) - $signed({1'b0, xa_reg});
        dys    = $signed({1'b0, yb_reg}) - $signed({1'b0, ya_reg});
        dx_abs = dxs[X_W] ? X_W'(-dxs) : dxs[X_W-1:0];
        dy_abs = dys[Y_W] ? Y_W'(-dys) : dys[Y_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg   <= opcode;
            xa_reg   <= x_a;
            ya_reg   <= y_a;
            xb_reg   <= x_b;
            yb_reg   <= y_b;
            rad_reg  <= radius;
            fill_reg <= fill;
        end
    end

    // Accumulate error per axis; step the axis when the error passes dist
    always_comb
    begin
        ex_sum  = ex_reg + {1'b0, dx_reg};
        ey_sum  = ey_reg + {2'b0, dy_reg};
        ex_next = ex_sum;
        ey_next = ey_sum;
        cx_next = cx_reg;
        cy_next = cy_reg;
        if (ex_sum > {1'b0, dist_reg})
        begin
            ex_next = ex_sum - {1'b0, dist_reg};
            cx_next = sx_neg_reg ? cx_reg - CW'(1) : cx_reg + CW'(1);
        end
        if (ey_sum > {1'b0, dist_reg})
        begin
            ey_next = ey_sum - {1'b0, dist_reg};
            cy_next = sy_neg_reg ? cy_reg - CW'(1) : cy_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.setup)
        begin
            cx_reg     <= $signed(CW'(xa_reg));
            cy_reg     <= $signed(CW'(ya_reg));
            dx_reg     <= dx_abs;
            dy_reg     <= dy_abs;
            sx_neg_reg <= dxs[X_W];
            sy_neg_reg <= dys[Y_W];
            dist_reg   <= (dx_abs > X_W'(dy_abs)) ? dx_abs : X_W'(dy_abs);
            ex_reg     <= '0;
            ey_reg     <= '0;
            n_reg      <= '0;
        end
        else if (ctl.line_step)
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            ex_reg <= ex_next;
            ey_reg <= ey_next;
            n_reg  <= n_reg + X_W'(1);
        end
    end

    // Circle: keep a^2, b^2 and r^2 by increments; test (a+1)^2 + b^2 > r^2
    always_comb
    begin
        asq_inc = asq_reg + SQ_W'({ca_reg[AB_W-2:0], 1'b1});
        bsq_dec = bsq_reg - SQ_W'({cb_reg[AB_W-2:0], 1'b0}) + SQ_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.setup)
        begin
            ca_reg  <= '0;
            cb_reg  <= $signed(AB_W'(rad_reg));
            asq_reg <= '0;
            bsq_reg <= SQ_W'(rad_reg) * SQ_W'(rad_reg);
            rsq_reg <= SQ_W'(rad_reg) * SQ_W'(rad_reg);
            k_reg   <= '0;
        end
        else
        begin
            if (ctl.oct_step)
            begin
                k_reg <= k_reg + 3'd1;
            end
            if (ctl.circ_step)
            begin
                if ({1'b0, asq_inc} + {1'b0, bsq_reg} > {1'b0, rsq_reg})
                begin
                    cb_reg  <= cb_reg - AB_W'(1);
                    bsq_reg <= bsq_dec;
                end
                else
                begin
                    ca_reg  <= ca_reg + AB_W'(1);
                    asq_reg <= asq_inc;
                end
            end
        end
    end

    // Eight symmetric points around the center
    always_comb
    begin
        logic signed [CW-1:0] xc, yc, ae, be;
        xc = $signed(CW'(xa_reg));
        yc = $signed(CW'(ya_reg));
        ae = CW'(ca_reg);
        be = CW'(cb_reg);
        unique case (k_reg)
            3'd0: begin oct_x = xc + ae; oct_y = yc - be; end
            3'd1: begin oct_x = xc - ae; oct_y = yc - be; end
            3'd2: begin oct_x = xc - ae; oct_y = yc + be; end
            3'd3: begin oct_x = xc + ae; oct_y = yc + be; end
            3'd4: begin oct_x = xc + be; oct_y = yc + ae; end
            3'd5: begin oct_x = xc + be; oct_y = yc - ae; end
            3'd6: begin oct_x = xc - be; oct_y = yc - ae; end
            default: begin oct_x = xc - be; oct_y = yc + ae; end
        endcase
    end

    always_comb
    begin
        pix_x    = (op_reg == OP_CIRCLE) ? oct_x : cx_reg;
        pix_y    = (op_reg == OP_CIRCLE) ? oct_y : cy_reg;
        pix_vis  = !pix_x[CW-1] && (int'(pix_x[CW-2:0]) < COLUMNS)
                   && !pix_y[CW-1] && (int'(pix_y[CW-2:0]) < ROWS);
        pix_addr = ADDR_W'(int'(pix_x[CW-2:0]) * PAGES + int'(pix_y[CW-2:3]));
        pix_mask = DATA_W'(1) << pix_y[2:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pix_rd)
        begin
            waddr_reg <= pix_addr;
            mask_reg  <= pix_mask;
            vis_reg   <= pix_vis;
        end
        if (ctl.pix_wr)
        begin
            res_data_reg <= vis_reg ? rd_data_reg : '0;
        end
    end

    always_comb
    begin
        wr_en   = ctl.pix_wr && vis_reg && (op_reg != OP_READ);
        wr_data = (op_reg == OP_CIRCLE || fill_reg) ? (rd_data_reg | mask_reg)
                                                    : (rd_data_reg & ~mask_reg);
    end

    // Frame memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.clear_en)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[waddr_reg] <= wr_data;
        end
        if (ctl.pix_rd)
        begin
            rd_data_reg <= mem[pix_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (ctl.clear_en)
        begin
            clr_cnt_reg <= sts.clr_last ? '0 : clr_cnt_reg + ADDR_W'(1);
        end
    end

    // Response register: holds a finished beat until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_read_reg <= (op_reg == OP_READ);
            out_data_reg <= (op_reg == OP_READ) ? res_data_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;
    assign is_read   = out_read_reg;

    always_comb
    begin
        sts.op        = op_reg;
        sts.line_last = (n_reg == dist_reg);
        sts.circ_cont = !cb_reg[AB_W-1] && ({bsq_reg, 1'b0} >= {1'b0, rsq_reg});
        sts.oct_last  = (k_reg == 3'd7);
        sts.clr_last  = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
        sts.out_free  = !out_valid_reg || out_ready;
    end
endmodule

// ===== tb/tb_page_framebuffer_line_circle_raster.sv =====
// Self-checking testbench for the page frame buffer rasterizer.
// Keeps a shadow frame store that mirrors point, line, circle, clear and read
// commands. Depends on pfb_pkg, pfb_cmd_if, pfb_rsp_if and the top level RTL.
`timescale 1ns / 100ps

module tb_page_framebuffer_line_circle_raster;
    import pfb_pkg::*;

    localparam int COLS        = COLUMNS_DEF;
    localparam int PGS         = PAGES_DEF;
    localparam int ROWS        = 8 * PGS;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE      = 16;
    localparam int SHOW_MAX    = 10;

    // Opcodes the block leaves undefined: no effect, plain zero response
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [X_W-1:0]  xa;
        logic [Y_W-1:0]  ya;
        logic [X_W-1:0]  xb;
        logic [Y_W-1:0]  yb;
        logic [R_W-1:0]  rad;
        logic            fill;
    } draw_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              is_read;
    } frame_beat_t;

    logic clk;
    logic rst_n;

    pfb_cmd_if cmd_bus ();
    pfb_rsp_if rsp_bus ();

    page_framebuffer_line_circle_raster uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    // Shadow of the frame store and the beats it predicts, oldest first
    logic [DATA_W-1:0] shadow_fb [0:COLS*PGS-1];
    frame_beat_t       pending_beats [$];

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int mismatches    = 0;
    int beats_checked = 0;
    int cycle_count   = 0;
    int op_count [0:7];
    int recent_x      = 0;

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stop a hung run; the limit is many times the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still owed",
                     cycle_count, pending_beats.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shadow frame store
    // ------------------------------------------------------------------

    // Drop anything off the visible area; no wrapping
    function automatic void plot(int x, int y, bit on);
        int idx;
        if (x < 0 || y < 0 || x >= COLS || y >= ROWS)
            return;
        idx = x * PGS + (y >> 3);
        shadow_fb[idx][y & 7] = on;
    endfunction

    // Error-accumulator DDA: span+1 steps, an axis moves once its error
    // strictly passes span. Upward lines step y by -1 with |dy|.
    function automatic void trace_line(int x0, int y0, int x1, int y1, bit on);
        int dx, dy, sx, sy, span, ex, ey, cx, cy, n;
        dx = x1 - x0;
        dy = y1 - y0;
        sx = (dx > 0) ? 1 : ((dx == 0) ? 0 : -1);
        sy = (dy > 0) ? 1 : ((dy == 0) ? 0 : -1);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        span = (dx > dy) ? dx : dy;
        ex = 0;
        ey = 0;
        cx = x0;
        cy = y0;
        for (n = 0; n <= span; n++)
        begin
            plot(cx, cy, on);
            ex += dx;
            ey += dy;
            if (ex > span)
            begin
                ex -= span;
                cx += sx;
            end
            if (ey > span)
            begin
                ey -= span;
                cy += sy;
            end
        end
    endfunction

    // Eight-way symmetric outline, always setting pixels
    function automatic void trace_circle(int xc, int yc, int r);
        int a, b;
        a = 0;
        b = r;
        while (b >= 0 && 2 * b * b >= r * r)
        begin
            plot(xc + a, yc - b, 1'b1);
            plot(xc - a, yc - b, 1'b1);
            plot(xc - a, yc + b, 1'b1);
            plot(xc + a, yc + b, 1'b1);
            plot(xc + b, yc + a, 1'b1);
            plot(xc + b, yc - a, 1'b1);
            plot(xc - b, yc - a, 1'b1);
            plot(xc - b, yc + a, 1'b1);
            a++;
            if (a * a + b * b - r * r > 0)
            begin
                b--;
                a--;
            end
        end
    endfunction

    function automatic void wipe_frame();
        foreach (shadow_fb[i])
            shadow_fb[i] = '0;
    endfunction

    // Apply one command to the shadow store and return the beat it owes
    function automatic frame_beat_t render_cmd(draw_cmd_t c);
        frame_beat_t beat;
        beat = '0;
        op_count[c.op]++;
        case (c.op)
            OP_POINT:  plot(int'(c.xa), int'(c.ya), c.fill);
            OP_LINE:   trace_line(int'(c.xa), int'(c.ya), int'(c.xb), int'(c.yb), c.fill);
            OP_CIRCLE: trace_circle(int'(c.xa), int'(c.ya), int'(c.rad));
            OP_CLEAR:  wipe_frame();
            OP_READ:
            begin
                beat.is_read = 1'b1;
                if (int'(c.xa) < COLS && int'(c.ya >> 3) < PGS)
                    beat.data = shadow_fb[int'(c.xa) * PGS + int'(c.ya >> 3)];
            end
            default: ;
        endcase
        return beat;
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------
    function automatic draw_cmd_t make_cmd(logic [OP_W-1:0] op, int xa, int ya,
                                           int xb, int yb, int rad, bit fill);
        draw_cmd_t c;
        c.op   = op;
        c.xa   = X_W'(xa);
        c.ya   = Y_W'(ya);
        c.xb   = X_W'(xb);
        c.yb   = Y_W'(yb);
        c.rad  = R_W'(rad);
        c.fill = fill;
        return c;
    endfunction

    // Send one beat. Valid is only lowered while idling, so back-to-back
    // beats keep it high with a single update per edge.
    task automatic push_cmd(input draw_cmd_t c);
        while ($urandom_range(99, 0) < src_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid  <= 1'b1;
        cmd_bus.opcode <= c.op;
        cmd_bus.x_a    <= c.xa;
        cmd_bus.y_a    <= c.ya;
        cmd_bus.x_b    <= c.xb;
        cmd_bus.y_b    <= c.yb;
        cmd_bus.radius <= c.rad;
        cmd_bus.fill   <= c.fill;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        pending_beats.push_back(render_cmd(c));
    endtask

    // Drop valid right after the last beat and hold until every owed
    // response has come back
    task automatic drain_responses();
        cmd_bus.valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    // Stall the response channel at the current rate, one draw per edge
    initial
    begin
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_bus.ready <= ($urandom_range(99, 0) >= snk_stall_pct);
        end
    end

    task automatic note_miss(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= SHOW_MAX)
            $display("[%0t] %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endtask

    // Compare each accepted response beat with the oldest prediction
    always @(posedge clk)
    begin : rsp_check
        frame_beat_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (pending_beats.size() == 0)
            begin
                note_miss("response with nothing owed", 0, rsp_bus.read_data);
            end
            else
            begin
                want = pending_beats.pop_front();
                beats_checked++;
                if (rsp_bus.read_data !== want.data)
                    note_miss("read_data", want.data, rsp_bus.read_data);
                if (rsp_bus.is_read !== want.is_read)
                    note_miss("is_read", want.is_read, rsp_bus.is_read);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corner pixels set and cleared, read back through the page bytes
    task automatic test_points();
        push_cmd(make_cmd(OP_POINT, 0, 0, 0, 0, 0, 1'b1));
        push_cmd(make_cmd(OP_POINT, 127, 63, 127, 63, 127, 1'b1));
        push_cmd(make_cmd(OP_POINT, 127, 0, 0, 63, 0, 1'b1));
        push_cmd(make_cmd(OP_POINT, 0, 63, 127, 0, 0, 1'b1));
        push_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 1'b0));
        push_cmd(make_cmd(OP_READ, 127, 56, 0, 0, 0, 1'b0));
        push_cmd(make_cmd(OP_POINT, 127, 63, 0, 0, 0, 1'b0));
        push_cmd(make_cmd(OP_READ, 127, 63, 0, 0, 0, 1'b0));
        drain_responses();
    endtask

    // Full diagonals both ways (upward one included), a one-pixel line,
    // a reversed horizontal and a vertical that clears
    task automatic test_lines();
        push_cmd(make_cmd(OP_LINE, 0, 0, 127, 63, 0, 1'b1));
        push_cmd(make_cmd(OP_LINE, 0, 63, 127, 0, 0, 1'b1));
        push_cmd(make_cmd(OP_LINE, 5, 5, 5, 5, 0, 1'b1));
        push_cmd(make_cmd(OP_LINE, 100, 10, 20, 10, 0, 1'b1));
        push_cmd(make_cmd(OP_LINE, 64, 63, 64, 0, 0, 1'b0));
        push_cmd(make_cmd(OP_READ, 64, 32, 0, 0, 0, 1'b0));
        push_cmd(make_cmd(OP_READ, 63, 24, 0, 0, 0, 1'b0));
        drain_responses();
    endtask

    // Zero radius, a largest circle clipped at the corner, a centered one
    task automatic test_circles();
        push_cmd(make_cmd(OP_CIRCLE, 10, 40, 0, 0, 0, 1'b0));
        push_cmd(make_cmd(OP_CIRCLE, 0, 0, 0, 0, 127, 1'b0));
        push_cmd(make_cmd(OP_CIRCLE, 64, 32, 0, 0, 20, 1'b0));
        push_cmd(make_cmd(OP_READ, 84, 32, 0, 0, 0, 1'b0));
        push_cmd(make_cmd(OP_READ, 10, 40, 0, 0, 0, 1'b0));
        drain_responses();
    endtask

    // Clear, confirm it, then the undefined opcodes, two of them with busy fields
    task automatic test_clear_and_spare();
        push_cmd(make_cmd(OP_CLEAR, 127, 63, 127, 63, 127, 1'b1));
        push_cmd(make_cmd(OP_READ, 64, 32, 0, 0, 0, 1'b0));
        push_cmd(make_cmd(OP_SPARE_A, 127, 63, 127, 63, 127, 1'b1));
        push_cmd(make_cmd(OP_SPARE_B, 3, 9, 3, 9, 9, 1'b1));
        push_cmd(make_cmd(OP_SPARE_C, 0, 0, 0, 0, 0, 1'b0));
        drain_responses();
    endtask

    // Mostly reads and drawing, with reads aimed near the last drawn x so
    // that fresh pixels get checked. Circles are small but for a few.
    function automatic draw_cmd_t random_cmd();
        draw_cmd_t c;
        int pick;
        c    = draw_cmd_t'({$urandom, $urandom});
        pick = $urandom_range(99, 0);
        if (pick < 18)
            c.op = OP_POINT;
        else if (pick < 40)
            c.op = OP_LINE;
        else if (pick < 58)
            c.op = OP_CIRCLE;
        else if (pick < 60)
            c.op = OP_CLEAR;
        else if (pick < 97)
            c.op = OP_READ;
        else
            c.op = OP_SPARE_A + OP_W'($urandom_range(2, 0));
        // Lean toward setting so the frame does not stay empty
        c.fill = ($urandom_range(9, 0) < 7);
        case (c.op)
            OP_CIRCLE:
            begin
                if ($urandom_range(11, 0) == 0)
                    c.rad = R_W'($urandom_range(127, 64));
                else
                    c.rad = R_W'($urandom_range(24, 0));
                recent_x = int'(c.xa);
            end
            OP_POINT:
                recent_x = int'(c.xa);
            OP_LINE:
                recent_x = $urandom_range(1, 0) ? int'(c.xa) : int'(c.xb);
            OP_READ:
            begin
                if ($urandom_range(1, 0))
                    c.xa = X_W'(recent_x + $urandom_range(4, 0) - 2);
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic test_random(input int src_pct, input int snk_pct, input int count);
        int n;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        for (n = 0; n < count; n++)
            push_cmd(random_cmd());
        drain_responses();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Hold every input at a known value before the first edge
        rst_n          <= 1'b0;
        cmd_bus.valid  <= 1'b0;
        cmd_bus.opcode <= OP_POINT;
        cmd_bus.x_a    <= '0;
        cmd_bus.y_a    <= '0;
        cmd_bus.x_b    <= '0;
        cmd_bus.y_b    <= '0;
        cmd_bus.radius <= '0;
        cmd_bus.fill   <= 1'b0;
        foreach (op_count[i])
            op_count[i] = 0;
        wipe_frame();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // The block sweeps its store after reset with ready low; the first
        // beat simply waits for it
        test_points();
        test_lines();
        test_circles();
        test_clear_and_spare();

        test_random(0, 0, 175);
        test_random(68, 0, 175);
        test_random(0, 68, 175);
        test_random(14, 14, 175);

        repeat (SETTLE) @(posedge clk);

        $display("covered %0d points, %0d lines, %0d circles, %0d clears, %0d reads, %0d spare",
                 op_count[OP_POINT], op_count[OP_LINE], op_count[OP_CIRCLE],
                 op_count[OP_CLEAR], op_count[OP_READ],
                 op_count[OP_SPARE_A] + op_count[OP_SPARE_B] + op_count[OP_SPARE_C]);
        $display("%0d response beats compared over four handshake mixes, %0d mismatches",
                 beats_checked, mismatches);
        if (mismatches == 0 && pending_beats.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
src/pfb_pkg.sv
src/pfb_cmd_if.sv
src/pfb_rsp_if.sv
src/pfb_ctrl.sv
src/pfb_dp.sv
src/page_framebuffer_line_circle_raster.sv
tb/tb_page_framebuffer_line_circle_raster.sv
